[hw/rtl/hpck_pkg.sv]
// Shared types and constants for the hanging plotter cable kinematics core.
// Used by the top level and the bench; depends on nothing.
`default_nettype none

package hpck_pkg;

    // Parameter defaults
    localparam int COORD_BITS_DEF       = 12;
    localparam int LENGTH_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int HALF_W   = 11;
    localparam int SPM_W    = 16;
    localparam int SPM_FRAC = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TOTAL_W  = 32;
    localparam int LEN_INT_BITS = 13;
    // distances from a motor never exceed 2*2047
    localparam int DIST_W   = 12;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int SUM_W    = SQ_W + 1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_MOVE     = 2'd0;
    localparam logic [OP_W-1:0] OP_PEN_UP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PEN_DOWN = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MM = 2'd2;

    // Register reset values
    localparam logic [HALF_W-1:0] HALF_WIDTH_RST   = 11'd500;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST  = 11'd500;
    localparam logic [SPM_W-1:0]  STEPS_PER_MM_RST = 16'd1280;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SQX,
        S_SQY,
        S_ROOT_GO,
        S_ROOT,
        S_STEPL,
        S_STEPR,
        S_APPLY,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_HOME,
        PH_LEFT,
        PH_RIGHT
    } phase_t;

endpackage

`default_nettype wire

[hw/rtl/hpck_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle (restoring form).
// Stand-alone; depends on no package or other module.
`default_nettype none

module hpck_isqrt #(
    parameter int ROOT_W = 21
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    output logic                       done,
    output logic [ROOT_W-1:0]          root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = ROOT_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[ROOT_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[hw/rtl/hpck_mul.sv]
// Shared unsigned multiplier with a registered product, one result a cycle.
// Serves both the squares of the distances and the step scaling.
`default_nettype none

module hpck_mul #(
    parameter int A_W = 21,
    parameter int B_W = 16
) (
    input  wire logic                 clk,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]        prod
);

    logic [A_W+B_W-1:0] prod_reg, prod_next;

    assign prod_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[hw/rtl/hanging_plotter_cable_kinematics_core.sv]
// Top level of the hanging plotter cable kinematics core: sequencer, state and ports.
// Depends on hpck_pkg, hpck_mul and hpck_isqrt.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  cmd      | cmd_valid / cmd_stall   | opcode, target_x, target_y
//  res      | res_valid / res_stall   | accepted, pen_down, left_target, right_target,
//           |                         | moved, position_x, position_y
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  Pen command, unknown opcode or rejected move: dispatch, then done loads the result.
//  Move: dispatch, then two square roots, each through square, square, start and root
//  (R = 13 + LENGTH_FRAC_BITS root bits), then scaling of both sides, update and done.
//  The next item can be taken as soon as the result appears.
//  The first item after reset also computes the home length before it is dispatched.
//  cmd_stall is high while an item is in flight; a waiting result holds only the done state.
`default_nettype none

module hanging_plotter_cable_kinematics_core #(
    parameter int COORD_BITS       = hpck_pkg::COORD_BITS_DEF,
    parameter int LENGTH_FRAC_BITS = hpck_pkg::LENGTH_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_stall,
    input  wire logic [hpck_pkg::OP_W-1:0]         opcode,
    input  wire logic signed [COORD_BITS-1:0]      target_x,
    input  wire logic signed [COORD_BITS-1:0]      target_y,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic                                   accepted,
    output logic                                   pen_down,
    output logic signed [hpck_pkg::TOTAL_W-1:0]    left_target,
    output logic signed [hpck_pkg::TOTAL_W-1:0]    right_target,
    output logic                                   moved,
    output logic signed [COORD_BITS-1:0]           position_x,
    output logic signed [COORD_BITS-1:0]           position_y,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hpck_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hpck_pkg::SPM_W-1:0]        cfg_data
);

    localparam int R_W   = hpck_pkg::LEN_INT_BITS + LENGTH_FRAC_BITS;
    localparam int P_W   = R_W + hpck_pkg::SPM_W;
    localparam int SHIFT = LENGTH_FRAC_BITS + hpck_pkg::SPM_FRAC;
    localparam int MAG_W = P_W - SHIFT;
    localparam int T_W   = hpck_pkg::TOTAL_W;
    localparam int EW    = ((COORD_BITS > hpck_pkg::HALF_W) ? COORD_BITS
                                                            : hpck_pkg::HALF_W) + 2;

    // configuration
    logic [hpck_pkg::HALF_W-1:0] hw_reg, hh_reg;
    logic [hpck_pkg::SPM_W-1:0]  spm_reg;

    // sequencer
    hpck_pkg::state_t state_reg, state_next;
    hpck_pkg::phase_t phase_reg, phase_next;

    // latched item
    logic [hpck_pkg::OP_W-1:0]    op_reg, op_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;

    // block state
    logic [R_W-1:0]               llen_reg, llen_next, rlen_reg, rlen_next;
    logic                         loaded_reg, loaded_next;
    logic [T_W-1:0]               ltot_reg, ltot_next, rtot_reg, rtot_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next, py_reg, py_next;
    logic                         pen_reg, pen_next;

    // working registers
    logic [hpck_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [R_W-1:0]               nl_reg, nl_next;
    logic                         negl_reg, negl_next, negr_reg, negr_next;
    logic [MAG_W-1:0]             magl_reg, magl_next;
    logic                         acc_reg, acc_next, mv_reg, mv_next;

    // result registers
    logic                         rv_reg, rv_next;
    logic                         racc_reg, racc_next, rpen_reg, rpen_next;
    logic [T_W-1:0]               rlt_reg, rlt_next, rrt_reg, rrt_next;
    logic                         rmv_reg, rmv_next;
    logic signed [COORD_BITS-1:0] rpx_reg, rpx_next, rpy_reg, rpy_next;

    // shared units
    logic [R_W-1:0]               mul_a;
    logic [hpck_pkg::SPM_W-1:0]   mul_b;
    logic [P_W-1:0]               prod;
    logic                         sq_start, sq_done;
    logic [2*R_W-1:0]             radicand;
    logic [R_W-1:0]               root;

    // datapath helpers
    logic signed [EW-1:0]         hw_e, hh_e, x_e, y_e, dx_e, dy_e;
    logic [hpck_pkg::DIST_W-1:0]  dx, dy;
    logic [hpck_pkg::SUM_W-1:0]   sq_sum;
    logic                         in_bounds;
    logic                         cmd_take;
    logic [MAG_W-1:0]             magr;
    logic [R_W-1:0]               diff_l, diff_r;

    hpck_mul #(
        .A_W (R_W),
        .B_W (hpck_pkg::SPM_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hpck_isqrt #(
        .ROOT_W (R_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (radicand),
        .done     (sq_done),
        .root     (root)
    );

    assign cfg_ready = 1'b1;
    assign cmd_stall = (state_reg != hpck_pkg::S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_comb
    begin
        hw_e = $signed({{(EW-hpck_pkg::HALF_W){1'b0}}, hw_reg});
        hh_e = $signed({{(EW-hpck_pkg::HALF_W){1'b0}}, hh_reg});
        x_e  = EW'(x_reg);
        y_e  = EW'(y_reg);
        in_bounds = (x_e > -hw_e) && (x_e < hw_e) && (y_e > -hh_e) && (y_e < hh_e);
        case (phase_reg)
            hpck_pkg::PH_HOME:
            begin
                dx_e = hw_e;
                dy_e = hh_e;
            end
            hpck_pkg::PH_LEFT:
            begin
                dx_e = hw_e + x_e;
                dy_e = hh_e - y_e;
            end
            default:
            begin
                dx_e = hw_e - x_e;
                dy_e = hh_e - y_e;
            end
        endcase
        dx = dx_e[hpck_pkg::DIST_W-1:0];
        dy = dy_e[hpck_pkg::DIST_W-1:0];
        sq_sum   = hpck_pkg::SUM_W'(sq_reg) + hpck_pkg::SUM_W'(prod[hpck_pkg::SQ_W-1:0]);
        radicand = {{(2*R_W-hpck_pkg::SUM_W-2*LENGTH_FRAC_BITS){1'b0}}, sq_sum,
                    {(2*LENGTH_FRAC_BITS){1'b0}}};
        diff_l = negl_next ? (llen_reg - nl_reg) : (nl_reg - llen_reg);
        diff_r = negr_next ? (rlen_reg - root) : (root - rlen_reg);
        magr   = prod[P_W-1:SHIFT];
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        llen_next   = llen_reg;
        rlen_next   = rlen_reg;
        loaded_next = loaded_reg;
        ltot_next   = ltot_reg;
        rtot_next   = rtot_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pen_next    = pen_reg;
        sq_next     = sq_reg;
        nl_next     = nl_reg;
        negl_next   = negl_reg;
        negr_next   = negr_reg;
        magl_next   = magl_reg;
        acc_next    = acc_reg;
        mv_next     = mv_reg;
        rv_next     = rv_reg && res_stall;
        racc_next   = racc_reg;
        rpen_next   = rpen_reg;
        rlt_next    = rlt_reg;
        rrt_next    = rrt_reg;
        rmv_next    = rmv_reg;
        rpx_next    = rpx_reg;
        rpy_next    = rpy_reg;
        sq_start    = 1'b0;
        mul_a       = '0;
        mul_b       = '0;

        case (state_reg)
            hpck_pkg::S_IDLE:
            begin
                if (cmd_take)
                begin
                    op_next  = opcode;
                    x_next   = target_x;
                    y_next   = target_y;
                    acc_next = 1'b0;
                    mv_next  = 1'b0;
                    if (!loaded_reg)
                    begin
                        phase_next = hpck_pkg::PH_HOME;
                        state_next = hpck_pkg::S_SQX;
                    end
                    else
                    begin
                        state_next = hpck_pkg::S_DISPATCH;
                    end
                end
            end
            hpck_pkg::S_DISPATCH:
            begin
                case (op_reg)
                    hpck_pkg::OP_PEN_UP:
                    begin
                        pen_next   = 1'b0;
                        acc_next   = 1'b1;
                        state_next = hpck_pkg::S_DONE;
                    end
                    hpck_pkg::OP_PEN_DOWN:
                    begin
                        pen_next   = 1'b1;
                        acc_next   = 1'b1;
                        state_next = hpck_pkg::S_DONE;
                    end
                    hpck_pkg::OP_MOVE:
                    begin
                        if (in_bounds)
                        begin
                            phase_next = hpck_pkg::PH_LEFT;
                            state_next = hpck_pkg::S_SQX;
                        end
                        else
                        begin
                            state_next = hpck_pkg::S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = hpck_pkg::S_DONE;
                    end
                endcase
            end
            hpck_pkg::S_SQX:
            begin
                mul_a      = R_W'(dx);
                mul_b      = hpck_pkg::SPM_W'(dx);
                state_next = hpck_pkg::S_SQY;
            end
            hpck_pkg::S_SQY:
            begin
                mul_a      = R_W'(dy);
                mul_b      = hpck_pkg::SPM_W'(dy);
                sq_next    = prod[hpck_pkg::SQ_W-1:0];
                state_next = hpck_pkg::S_ROOT_GO;
            end
            hpck_pkg::S_ROOT_GO:
            begin
                sq_start   = 1'b1;
                state_next = hpck_pkg::S_ROOT;
            end
            hpck_pkg::S_ROOT:
            begin
                if (sq_done)
                begin
                    case (phase_reg)
                        hpck_pkg::PH_HOME:
                        begin
                            llen_next   = root;
                            rlen_next   = root;
                            loaded_next = 1'b1;
                            state_next  = hpck_pkg::S_DISPATCH;
                        end
                        hpck_pkg::PH_LEFT:
                        begin
                            nl_next    = root;
                            phase_next = hpck_pkg::PH_RIGHT;
                            state_next = hpck_pkg::S_SQX;
                        end
                        default:
                        begin
                            // right root stays on the root unit's output until the next start
                            negl_next  = nl_reg < llen_reg;
                            negr_next  = root < rlen_reg;
                            state_next = hpck_pkg::S_STEPL;
                        end
                    endcase
                end
            end
            hpck_pkg::S_STEPL:
            begin
                mul_a      = diff_l;
                mul_b      = spm_reg;
                state_next = hpck_pkg::S_STEPR;
            end
            hpck_pkg::S_STEPR:
            begin
                magl_next  = prod[P_W-1:SHIFT];
                mul_a      = diff_r;
                mul_b      = spm_reg;
                state_next = hpck_pkg::S_APPLY;
            end
            hpck_pkg::S_APPLY:
            begin
                // right-hand change is negated
                ltot_next = negl_reg ? (ltot_reg - T_W'(magl_reg)) : (ltot_reg + T_W'(magl_reg));
                rtot_next = negr_reg ? (rtot_reg + T_W'(magr)) : (rtot_reg - T_W'(magr));
                llen_next = nl_reg;
                rlen_next = root;
                acc_next  = 1'b1;
                if ((magl_reg != '0) || (magr != '0))
                begin
                    px_next = x_reg;
                    py_next = y_reg;
                    mv_next = 1'b1;
                end
                state_next = hpck_pkg::S_DONE;
            end
            hpck_pkg::S_DONE:
            begin
                if (!rv_reg || !res_stall)
                begin
                    rv_next    = 1'b1;
                    racc_next  = acc_reg;
                    rpen_next  = pen_reg;
                    rlt_next   = ltot_reg;
                    rrt_next   = rtot_reg;
                    rmv_next   = mv_reg;
                    rpx_next   = px_reg;
                    rpy_next   = py_reg;
                    state_next = hpck_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hpck_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hpck_pkg::S_IDLE;
            phase_reg  <= hpck_pkg::PH_HOME;
            hw_reg     <= hpck_pkg::HALF_WIDTH_RST;
            hh_reg     <= hpck_pkg::HALF_HEIGHT_RST;
            spm_reg    <= hpck_pkg::STEPS_PER_MM_RST;
            llen_reg   <= '0;
            rlen_reg   <= '0;
            loaded_reg <= 1'b0;
            ltot_reg   <= '0;
            rtot_reg   <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            pen_reg    <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            llen_reg   <= llen_next;
            rlen_reg   <= rlen_next;
            loaded_reg <= loaded_next;
            ltot_reg   <= ltot_next;
            rtot_reg   <= rtot_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pen_reg    <= pen_next;
            rv_reg     <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hpck_pkg::REG_HALF_WIDTH:   hw_reg  <= cfg_data[hpck_pkg::HALF_W-1:0];
                    hpck_pkg::REG_HALF_HEIGHT:  hh_reg  <= cfg_data[hpck_pkg::HALF_W-1:0];
                    hpck_pkg::REG_STEPS_PER_MM: spm_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        sq_reg   <= sq_next;
        nl_reg   <= nl_next;
        negl_reg <= negl_next;
        negr_reg <= negr_next;
        magl_reg <= magl_next;
        acc_reg  <= acc_next;
        mv_reg   <= mv_next;
        racc_reg <= racc_next;
        rpen_reg <= rpen_next;
        rlt_reg  <= rlt_next;
        rrt_reg  <= rrt_next;
        rmv_reg  <= rmv_next;
        rpx_reg  <= rpx_next;
        rpy_reg  <= rpy_next;
    end

    assign res_valid    = rv_reg;
    assign accepted     = racc_reg;
    assign pen_down     = rpen_reg;
    assign left_target  = $signed(rlt_reg);
    assign right_target = $signed(rrt_reg);
    assign moved        = rmv_reg;
    assign position_x   = rpx_reg;
    assign position_y   = rpy_reg;

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for hanging_plotter_cable_kinematics_core: a directed table, then random
// moves and pen commands over several geometries, checked against fixed results or an in-bench predictor.
// Depends on hpck_pkg and the core RTL only.

module tb;

    import hpck_pkg::*;

    localparam int CW  = COORD_BITS_DEF;
    localparam int LFB = LENGTH_FRAC_BITS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // root unit twice plus home length plus update, rounded up
    localparam int SETTLE = 2 * (LEN_INT_BITS + LFB) + 12 + (LEN_INT_BITS + LFB) + 5 + 20;
    localparam int RUN_LIMIT = 400000;
    localparam int N_SETTINGS = 8;
    localparam int ITEMS_PER_SETTING = 75;

    typedef struct packed {
        logic                   accepted;
        logic                   pen_down;
        logic [TOTAL_W-1:0]     left_target;
        logic [TOTAL_W-1:0]     right_target;
        logic                   moved;
        logic signed [CW-1:0]   position_x;
        logic signed [CW-1:0]   position_y;
    } plot_res_t;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic                   typed;
        plot_res_t              want;
    } plot_row_t;

    // results readable straight off the reset state: pen down or up at home, nothing stepped
    localparam plot_res_t DOWN_AT_HOME_OK      = '{1'b1, 1'b1, 32'd0, 32'd0, 1'b0, 12'sd0, 12'sd0};
    localparam plot_res_t DOWN_AT_HOME_REFUSED = '{1'b0, 1'b1, 32'd0, 32'd0, 1'b0, 12'sd0, 12'sd0};
    localparam plot_res_t UP_AT_HOME_OK        = '{1'b1, 1'b0, 32'd0, 32'd0, 1'b0, 12'sd0, 12'sd0};
    localparam plot_res_t PREDICTED            = '0;

    localparam plot_row_t DIRECTED [22] = '{
        '{OP_PEN_DOWN, 12'sd0,    12'sd0,    1'b1, DOWN_AT_HOME_OK},
        '{OP_MOVE,     12'sd0,    12'sd0,    1'b1, DOWN_AT_HOME_OK},
        '{OP_MOVE,     12'sd500,  12'sd0,    1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_MOVE,     -12'sd500, 12'sd0,    1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_MOVE,     12'sd0,    12'sd500,  1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_MOVE,     12'sd0,    -12'sd500, 1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_MOVE,     12'sd2047, 12'sd2047, 1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_MOVE,     12'h800,   12'h800,   1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_UNUSED,   12'sd0,    12'sd0,    1'b1, DOWN_AT_HOME_REFUSED},
        '{OP_PEN_UP,   12'h800,   12'sd2047, 1'b1, UP_AT_HOME_OK},
        '{OP_MOVE,     12'sd499,  12'sd499,  1'b0, PREDICTED},
        '{OP_MOVE,     -12'sd499, -12'sd499, 1'b0, PREDICTED},
        '{OP_MOVE,     12'sd499,  -12'sd499, 1'b0, PREDICTED},
        '{OP_MOVE,     -12'sd499, 12'sd499,  1'b0, PREDICTED},
        '{OP_MOVE,     12'sd1,    12'sd0,    1'b0, PREDICTED},
        '{OP_MOVE,     12'sd0,    12'sd0,    1'b0, PREDICTED},
        '{OP_MOVE,     12'sd0,    12'sd0,    1'b0, PREDICTED},
        '{OP_PEN_DOWN, 12'sd123,  -12'sd45,  1'b0, PREDICTED},
        '{OP_UNUSED,   12'sd2047, 12'h800,   1'b0, PREDICTED},
        '{OP_MOVE,     -12'sd1,   -12'sd1,   1'b0, PREDICTED},
        '{OP_MOVE,     12'sd500,  12'sd499,  1'b0, PREDICTED},
        '{OP_PEN_UP,   12'sd0,    12'sd0,    1'b0, PREDICTED}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic [OP_W-1:0] opcode = OP_MOVE;
    logic signed [CW-1:0] target_x = '0;
    logic signed [CW-1:0] target_y = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic accepted;
    logic pen_down;
    logic signed [TOTAL_W-1:0] left_target;
    logic signed [TOTAL_W-1:0] right_target;
    logic moved;
    logic signed [CW-1:0] position_x;
    logic signed [CW-1:0] position_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_WIDTH;
    logic [SPM_W-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    logic [HALF_W-1:0] geo_half_w = HALF_WIDTH_RST;
    logic [HALF_W-1:0] geo_half_h = HALF_HEIGHT_RST;
    logic [SPM_W-1:0] geo_spm = STEPS_PER_MM_RST;
    longint unsigned len_left = 0;
    longint unsigned len_right = 0;
    logic lens_loaded = 1'b0;
    logic [TOTAL_W-1:0] steps_left = '0;
    logic [TOTAL_W-1:0] steps_right = '0;
    logic signed [CW-1:0] pos_x = '0;
    logic signed [CW-1:0] pos_y = '0;
    logic pen_is_down = 1'b0;

    plot_res_t expected_results [$];
    int fails = 0;
    int items_sent = 0;
    int results_seen = 0;
    int moves_stepped = 0;
    int items_refused = 0;
    int cycle_count = 0;
    int burst_left = 0;
    logic signed [CW-1:0] last_x = '0;
    logic signed [CW-1:0] last_y = '0;

    hanging_plotter_cable_kinematics_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .opcode       (opcode),
        .target_x     (target_x),
        .target_y     (target_y),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .accepted     (accepted),
        .pen_down     (pen_down),
        .left_target  (left_target),
        .right_target (right_target),
        .moved        (moved),
        .position_x   (position_x),
        .position_y   (position_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // floor(sqrt(dx^2 + dy^2)) in Q13.LFB
    function automatic longint unsigned cable_root(input int dx, input int dy);
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        sq = 64'(dx * dx) + 64'(dy * dy);
        sq = sq << (2 * LFB);
        root = 0;
        for (int b = 23; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root;
    endfunction

    // length change times steps/mm, truncated toward zero
    function automatic longint step_delta(input longint unsigned new_len,
                                          input longint unsigned old_len);
        longint unsigned mag;
        mag = (new_len >= old_len) ? new_len - old_len : old_len - new_len;
        mag = (mag * 64'(geo_spm)) >> (LFB + SPM_FRAC);
        return (new_len < old_len) ? -$signed(mag) : $signed(mag);
    endfunction

    task automatic plot_step(input logic [OP_W-1:0] op, input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y, output plot_res_t r);
        int sx;
        int sy;
        int w;
        int h;
        longint unsigned new_l;
        longint unsigned new_r;
        longint d_l;
        longint d_r;
        sx = x;
        sy = y;
        w = int'(geo_half_w);
        h = int'(geo_half_h);
        r = '0;
        if (!lens_loaded)
        begin
            len_left = cable_root(w, h);
            len_right = len_left;
            lens_loaded = 1'b1;
        end
        if (op == OP_PEN_UP)
        begin
            pen_is_down = 1'b0;
            r.accepted = 1'b1;
        end
        else if (op == OP_PEN_DOWN)
        begin
            pen_is_down = 1'b1;
            r.accepted = 1'b1;
        end
        else if (op == OP_MOVE && sx > -w && sx < w && sy > -h && sy < h)
        begin
            new_l = cable_root(w + sx, h - sy);
            new_r = cable_root(w - sx, h - sy);
            d_l = step_delta(new_l, len_left);
            d_r = -step_delta(new_r, len_right);
            steps_left += 32'(d_l);
            steps_right += 32'(d_r);
            len_left = new_l;
            len_right = new_r;
            if (d_l != 0 || d_r != 0)
            begin
                pos_x = x;
                pos_y = y;
                r.moved = 1'b1;
            end
            r.accepted = 1'b1;
        end
        r.pen_down = pen_is_down;
        r.left_target = steps_left;
        r.right_target = steps_right;
        r.position_x = pos_x;
        r.position_y = pos_y;
    endtask

    // offer one item, hold it until taken, then queue what it should produce
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y, input logic typed,
                             input plot_res_t want);
        plot_res_t pred;
        cmd_valid <= 1'b1;
        opcode <= op;
        target_x <= x;
        target_y <= y;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        plot_step(op, x, y, pred);
        expected_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic maybe_gap();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic random_item();
        int pick;
        int w;
        int h;
        int xi;
        int yi;
        logic [OP_W-1:0] op;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        w = int'(geo_half_w);
        h = int'(geo_half_h);
        pick = $urandom_range(0, 99);
        op = OP_MOVE;
        x = CW'($urandom);
        y = CW'($urandom);
        if (pick < 55)
        begin
            xi = int'($urandom_range(0, 2 * w - 2)) - (w - 1);
            yi = int'($urandom_range(0, 2 * h - 2)) - (h - 1);
            x = CW'(xi);
            y = CW'(yi);
        end
        else if (pick < 65)
        begin
            // on or just inside the box edge
            xi = w - int'($urandom_range(0, 1));
            yi = h - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
                xi = -xi;
            if ($urandom_range(0, 1) == 1)
                yi = -yi;
            x = CW'(xi);
            y = CW'(yi);
        end
        else if (pick < 70)
        begin
            x = last_x;
            y = last_y;
        end
        else if (pick < 80)
            op = ($urandom_range(0, 1) == 1) ? OP_PEN_UP : OP_PEN_DOWN;
        else if (pick < 84)
            op = OP_UNUSED;
        else
            op = OP_W'($urandom);
        last_x = x;
        last_y = y;
        send_item(op, x, y, 1'b0, PREDICTED);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // only between phases: drain, let the core settle, then rewrite all three registers
    task automatic set_geometry(input logic [HALF_W-1:0] w, input logic [HALF_W-1:0] h,
                                input logic [SPM_W-1:0] spm);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        // upper bits of the narrow registers are don't-care
        write_reg(REG_HALF_WIDTH, {5'($urandom), w});
        write_reg(REG_HALF_HEIGHT, {5'($urandom), h});
        write_reg(REG_STEPS_PER_MM, spm);
        cfg_valid <= 1'b0;
        geo_half_w = w;
        geo_half_h = h;
        geo_spm = spm;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want_v), $signed(got_v));
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        plot_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected");
                fails++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(accepted));
                check_field("pen_down", 32'(want.pen_down), 32'(pen_down));
                check_field("left_target", want.left_target, left_target);
                check_field("right_target", want.right_target, right_target);
                check_field("moved", 32'(want.moved), 32'(moved));
                check_field("position_x", 32'(want.position_x), 32'(position_x));
                check_field("position_y", 32'(want.position_y), 32'(position_y));
                results_seen++;
                if (want.moved)
                    moves_stepped++;
                if (!want.accepted)
                    items_refused++;
            end
        end
    end

    // result side back-pressure; a long hold-off now and then fills the core up
    initial
    begin : res_pacing
        int n;
        int mode;
        int seg_left;
        int hold_left;
        n = 0;
        mode = 0;
        seg_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            n++;
            if (hold_left == 0 && n % 15000 == 4000)
                hold_left = 400;
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 150);
            end
            else
                seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (mode == 0)
                res_stall <= 1'b0;
            else if (mode == 1)
                res_stall <= ($urandom_range(0, 3) == 0);
            else if (mode == 2)
                res_stall <= ($urandom_range(0, 3) != 0);
            else
                res_stall <= n[2];
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned set_w [N_SETTINGS];
        int unsigned set_h [N_SETTINGS];
        int unsigned set_spm [N_SETTINGS];
        set_w = '{2047, 1, 1, 2047, 500, 0, 0, 0};
        set_h = '{2047, 1, 2047, 1, 500, 0, 0, 0};
        set_spm = '{65535, 1, 256, 65535, 1280, 0, 0, 0};
        for (int p = 5; p < N_SETTINGS; p++)
        begin
            set_w[p] = $urandom_range(1, 2047);
            set_h[p] = $urandom_range(1, 2047);
            set_spm[p] = $urandom_range(1, 65535);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, home lengths loaded by the first item
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (i > 0)
                maybe_gap();
            send_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end
        cmd_valid <= 1'b0;

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            set_geometry(HALF_W'(set_w[p]), HALF_W'(set_h[p]), SPM_W'(set_spm[p]));
            for (int k = 0; k < ITEMS_PER_SETTING; k++)
            begin
                if (k > 0)
                    maybe_gap();
                random_item();
            end
            cmd_valid <= 1'b0;
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d items over %0d geometries plus the reset one.",
                 items_sent, N_SETTINGS);
        $display("%0d results checked: %0d moves stepped the motors, %0d items refused.",
                 results_seen, moves_stepped, items_refused);
        if (fails == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
